>>> rtl/bldc6_pkg.sv
package bldc6_pkg;

    localparam int COUNT_BITS = 16;

    localparam int DUTY_W     = 24;
    localparam int PERIOD_W   = 20;
    localparam int STEPS_W    = 16;
    localparam int CMP_W      = 15;
    localparam int RELOAD_W   = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int M_TDATA_W  = 48;

    // Width used when the step counter is compared against a step limit.
    localparam int CNT_CMP_W = (COUNT_BITS > STEPS_W) ? COUNT_BITS : STEPS_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Reset values of the configuration registers.
    localparam logic [DUTY_W-1:0]   DUTY_START_RST   = 24'd220000;
    localparam logic [DUTY_W-1:0]   DUTY_STEP_RST    = 24'd56;
    localparam logic [PERIOD_W-1:0] PERIOD_START_RST = 20'd40000;
    localparam logic [PERIOD_W-1:0] PERIOD_STEP_RST  = 20'd24;
    localparam logic [STEPS_W-1:0]  RAMP_STEPS_RST   = 16'd1250;
    localparam logic [STEPS_W-1:0]  HOLD_STEPS_RST   = 16'd1000;

    // Division by constants through a reciprocal multiply:
    // floor(x / 1000) = (x * 17179870) >> 34 for all 24-bit x,
    // floor(x / 10)   = (x * 838861) >> 23 for all 20-bit x.
    localparam int DIV1000_MUL_W = 25;
    localparam int DIV1000_SHIFT = 34;
    localparam logic [DIV1000_MUL_W-1:0] DIV1000_MUL = 25'd17179870;
    localparam int DIV10_MUL_W = 20;
    localparam int DIV10_SHIFT = 23;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 20'd838861;
    localparam int DIV10_QUO_W = PERIOD_W + DIV10_MUL_W - DIV10_SHIFT;

    localparam logic [2:0] PHASE_FIRST = 3'd1;
    localparam logic [2:0] PHASE_LAST  = 3'd6;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DUTY_START   = 3'd0,
        CFG_DUTY_STEP    = 3'd1,
        CFG_PERIOD_START = 3'd2,
        CFG_PERIOD_STEP  = 3'd3,
        CFG_RAMP_STEPS   = 3'd4,
        CFG_HOLD_STEPS   = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_RAMP     = 2'd0,
        MODE_HOLD     = 2'd1,
        MODE_HANDOVER = 2'd2,
        MODE_CLOSED   = 2'd3
    } run_mode_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_ZC   = 1'b1
    } op_t;

    // State as it stands after one event, handed to the output stage.
    typedef struct packed {
        logic                acted;
        logic [2:0]          phase;
        logic [DUTY_W-1:0]   duty;
        logic [PERIOD_W-1:0] period;
        run_mode_t           mode;
        logic [2:0]          watch;
    } snap_t;

    function automatic logic [2:0] high_enable_of(input logic [2:0] phase);
        logic [2:0] r;
        unique case (phase)
            3'd0, 3'd1, 3'd2: r = 3'b001;
            3'd3, 3'd4:       r = 3'b010;
            3'd5, 3'd6:       r = 3'b100;
            default:          r = 3'b001;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] low_enable_of(input logic [2:0] phase);
        logic [2:0] r;
        unique case (phase)
            3'd0, 3'd1, 3'd6: r = 3'b010;
            3'd2, 3'd3:       r = 3'b100;
            3'd4, 3'd5:       r = 3'b001;
            default:          r = 3'b010;
        endcase
        return r;
    endfunction

    // Floating phase whose back-EMF is watched next.
    function automatic logic [2:0] watch_of(input logic [2:0] phase);
        logic [2:0] r;
        unique case (phase)
            3'd1, 3'd4: r = 3'b100;
            3'd2, 3'd5: r = 3'b010;
            3'd3, 3'd6: r = 3'b001;
            default:    r = 3'b000;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] zc_phase_of(input logic [1:0] ch, input logic rising);
        logic [2:0] r;
        unique case (ch)
            2'd0:    r = rising ? 3'd1 : 3'd4;
            2'd1:    r = rising ? 3'd3 : 3'd6;
            2'd2:    r = rising ? 3'd5 : 3'd2;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/six_step_bldc_commutator_core.sv
// Six-step commutator core: an input transfer is registered in the state stage, then in the output divider stage.
// Throughput is one event per cycle while the output is not stalled; the state update and the output divider stage
// are each a single register stage, so back-to-back transfers flow without bubbles.
// Reset is synchronous on aresetn low: configuration returns to its default values,
// the motor state returns to ramp mode, phase 0 and all channels watched,
// and both pipeline stages are emptied.
module six_step_bldc_commutator_core
    import bldc6_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port; index follows the register list.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Event input.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [1:0] zc_channel, [2] zc_rising, [7:3] zero
    input  logic [0:0]            s_tuser,   // [0] op
    // Result output.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [0] acted, [3:1] step_phase,
                                             // [6:4] high_enable, [9:7] low_enable,
                                             // [24:10] compare_value,
                                             // [40:25] reload_value, [42:41] run_mode,
                                             // [45:43] watch_mask, [47:46] zero
);

    // The first stage applies one event to the commutation state and keeps a
    // copy of the resulting state. The second stage turns that copy into the
    // bridge enables, the compare value and the reload value, and holds the
    // result until the downstream side takes the transfer.
    logic  snap_valid;
    logic  snap_ready;
    snap_t snap;

    // Unused padding bits of the input word.
    logic  unused_pad;
    assign unused_pad = ^s_tdata[7:3];

    bldc6_state u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .op         (s_tuser[0]),
        .zc_channel (s_tdata[1:0]),
        .zc_rising  (s_tdata[2]),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    bldc6_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

>>> rtl/bldc6_state.sv
module bldc6_state
    import bldc6_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [1:0]            zc_channel,
    input  logic                  zc_rising,
    output logic                  snap_valid,
    output snap_t                 snap,
    input  logic                  snap_ready
);

    logic [DUTY_W-1:0]     duty_step_reg;
    logic [PERIOD_W-1:0]   period_step_reg;
    logic [STEPS_W-1:0]    ramp_steps_reg, hold_steps_reg;

    run_mode_t             mode_reg, mode_next;
    logic [2:0]            phase_reg, phase_next;
    logic [COUNT_BITS-1:0] count_reg, count_next, count_bump;
    logic [DUTY_W-1:0]     duty_reg, duty_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [2:0]            watch_reg, watch_next;
    logic                  acted;

    logic                  snap_valid_reg;
    snap_t                 snap_reg;

    logic                  accept;
    logic                  fresh;
    logic [2:0]            ch_mask;
    logic [2:0]            zc_phase;

    assign in_ready   = !snap_valid_reg || snap_ready;
    assign accept     = in_valid && in_ready;
    assign fresh      = (mode_reg == MODE_RAMP) && (phase_reg == 3'd0);
    assign ch_mask    = 3'b001 << zc_channel;
    assign zc_phase   = zc_phase_of(zc_channel, zc_rising);
    assign count_bump = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_comb begin
        mode_next   = mode_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        duty_next   = duty_reg;
        period_next = period_reg;
        watch_next  = watch_reg;
        acted       = 1'b0;
        if (accept) begin
            if (op == OP_TICK) begin
                if (mode_reg != MODE_CLOSED) begin
                    acted = 1'b1;
                    unique case (mode_reg)
                        MODE_RAMP: begin
                            duty_next   = (duty_reg > duty_step_reg) ?
                                          duty_reg - duty_step_reg : '0;
                            period_next = (period_reg > period_step_reg) ?
                                          period_reg - period_step_reg : '0;
                            if (CNT_CMP_W'(count_bump) >= CNT_CMP_W'(ramp_steps_reg)) begin
                                mode_next  = MODE_HOLD;
                                count_next = '0;
                            end else begin
                                count_next = count_bump;
                            end
                        end
                        MODE_HOLD: begin
                            count_next = count_bump;
                            if (CNT_CMP_W'(count_bump) >= CNT_CMP_W'(hold_steps_reg)) begin
                                mode_next = MODE_HANDOVER;
                            end
                        end
                        default: begin
                            mode_next = MODE_CLOSED;
                        end
                    endcase
                    phase_next = (phase_reg >= PHASE_LAST) ? PHASE_FIRST : phase_reg + 1'b1;
                end
            end else if ((mode_reg == MODE_CLOSED) && ((watch_reg & ch_mask) != 3'b000)) begin
                // Channel 3 gives an empty mask and falls out as ignored.
                acted      = 1'b1;
                phase_next = zc_phase;
                watch_next = (watch_reg & ~ch_mask) | watch_of(zc_phase);
            end
        end else if (cfg_wr_en && fresh) begin
            // Start values also load the live values until the first tick.
            if (cfg_addr == CFG_DUTY_START) begin
                duty_next = cfg_wdata[DUTY_W-1:0];
            end
            if (cfg_addr == CFG_PERIOD_START) begin
                period_next = cfg_wdata[PERIOD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_step_reg    <= DUTY_STEP_RST;
            period_step_reg  <= PERIOD_STEP_RST;
            ramp_steps_reg   <= RAMP_STEPS_RST;
            hold_steps_reg   <= HOLD_STEPS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DUTY_STEP:    duty_step_reg    <= cfg_wdata[DUTY_W-1:0];
                CFG_PERIOD_STEP:  period_step_reg  <= cfg_wdata[PERIOD_W-1:0];
                CFG_RAMP_STEPS:   ramp_steps_reg   <= cfg_wdata[STEPS_W-1:0];
                CFG_HOLD_STEPS:   hold_steps_reg   <= cfg_wdata[STEPS_W-1:0];
                default: begin
                    // Start values only matter through the live load above.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_RAMP;
            phase_reg      <= 3'd0;
            count_reg      <= '0;
            duty_reg       <= DUTY_START_RST;
            period_reg     <= PERIOD_START_RST;
            watch_reg      <= 3'b111;
            snap_valid_reg <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            duty_reg   <= duty_next;
            period_reg <= period_next;
            watch_reg  <= watch_next;
            if (accept) begin
                snap_valid_reg <= 1'b1;
            end else if (snap_ready) begin
                snap_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            snap_reg.acted  <= acted;
            snap_reg.phase  <= phase_next;
            snap_reg.duty   <= duty_next;
            snap_reg.period <= period_next;
            snap_reg.mode   <= mode_next;
            snap_reg.watch  <= watch_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

>>> rtl/bldc6_emit.sv
module bldc6_emit
    import bldc6_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 snap_valid,
    input  snap_t                snap,
    output logic                 snap_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int PROD1000_W = DUTY_W + DIV1000_MUL_W;
    localparam int PROD10_W   = PERIOD_W + DIV10_MUL_W;

    logic [PROD1000_W-1:0]  prod1000;
    logic [PROD10_W-1:0]    prod10;
    logic [CMP_W-1:0]       compare_value;
    logic [DIV10_QUO_W-1:0] reload_quo;
    logic [RELOAD_W-1:0]    reload_value;
    logic [M_TDATA_W-1:0]   tdata_next;

    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    assign snap_ready = !m_tvalid_reg || m_tready;

    assign prod1000      = PROD1000_W'(snap.duty) * PROD1000_W'(DIV1000_MUL);
    assign prod10        = PROD10_W'(snap.period) * PROD10_W'(DIV10_MUL);
    assign compare_value = prod1000[DIV1000_SHIFT +: CMP_W];
    assign reload_quo    = prod10[DIV10_SHIFT +: DIV10_QUO_W];
    assign reload_value  = (reload_quo > DIV10_QUO_W'({RELOAD_W{1'b1}})) ?
                           {RELOAD_W{1'b1}} : reload_quo[RELOAD_W-1:0];

    assign tdata_next = {
        2'b00,
        snap.watch,
        snap.mode,
        reload_value,
        compare_value,
        low_enable_of(snap.phase),
        high_enable_of(snap.phase),
        snap.phase,
        snap.acted
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (snap_ready) begin
            m_tvalid_reg <= snap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && snap_ready) begin
            m_tdata_reg <= tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/bldc6_checker.sv
module bldc6_checker
    import bldc6_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Exactly one high-side and one low-side switch is enabled.
    a_bridge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[6:4]) && $onehot(m_tdata[9:7])
                     && (m_tdata[6:4] != m_tdata[9:7]))
        else $error("bridge enables are not one high and one low switch");

    // Phase stays within 0..6 and the compare value within its range.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:1] != 3'd7) && (m_tdata[24:10] <= 15'd16777))
        else $error("phase or compare value out of range");

    // Reset empties the output stage.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind six_step_bldc_commutator_core bldc6_checker u_bldc6_checker (.*);
